// ===== hw/rtl/crop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coin row pick package
// Shared widths, unit operation codes and the control bundle that the
// sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package crop_pkg;

    // Field widths fixed by the interface.
    localparam int COIN_W = 16;
    localparam int RES_W  = 22;

    // Operation codes of the shared compare-add unit.
    localparam logic ALU_MINADD = 1'b0;
    localparam logic ALU_MAX    = 1'b1;

    // Per-cycle control from the sequencer to the datapath.
    typedef struct packed {
        logic coin_wr;  // store the incoming coin
        logic cap_x;    // capture the left-left neighbor and the left coin
        logic left;     // form the take-left total, capture middle and right coin
        logic right;    // form the take-right total
        logic tab_wr;   // pick the larger total and write the cell
        logic near;     // interval shorter than three coins: neighbors read as zero
    } ctl_t;

endpackage

// ===== hw/rtl/crop_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coin row pick shared arithmetic unit
// One compare-add unit: either a plus the smaller of b and c, or the larger
// of b and c. The sequencer uses it three times per table cell.
// ----------------------------------------------------------------------------
module crop_alu
    import crop_pkg::*;
#(
    parameter int DATA_W = 22
)
(
    input  logic              op,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic [DATA_W-1:0] c,
    output logic [DATA_W-1:0] y
);

    logic              b_less;
    logic [DATA_W-1:0] smaller;
    logic [DATA_W-1:0] larger;

    // One comparator serves both operations.
    assign b_less  = (b < c);
    assign smaller = b_less ? b : c;
    assign larger  = b_less ? c : b;

    always_comb
    begin
        case (op)
            ALU_MINADD: y = a + smaller;
            ALU_MAX:    y = larger;
            default:    y = larger;
        endcase
    end

endmodule

// ===== hw/rtl/crop_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coin row pick datapath
// Holds the coin store and the interval table, the operand registers of one
// cell, and the shared compare-add unit that builds each cell value.
// ----------------------------------------------------------------------------
module crop_datapath
    import crop_pkg::*;
#(
    parameter int MAX_COINS = 64,
    parameter int IDX_W     = 6,
    parameter int TAB_AW    = 12,
    parameter int DATA_W    = 22
)
(
    input  logic              clk,
    input  ctl_t              ctl,
    input  logic [IDX_W-1:0]  coin_wr_addr,
    input  logic [COIN_W-1:0] coin_wr_data,
    input  logic [IDX_W-1:0]  coin_rd_addr,
    input  logic [TAB_AW-1:0] tab_rd_addr,
    input  logic [TAB_AW-1:0] tab_wr_addr,
    output logic [DATA_W-1:0] cell_value
);

    logic [COIN_W-1:0] coin_mem [MAX_COINS];
    logic [DATA_W-1:0] tab_mem  [MAX_COINS*MAX_COINS];

    logic [COIN_W-1:0] coin_q;
    logic [DATA_W-1:0] tab_q;
    logic [DATA_W-1:0] nb_val;

    logic [COIN_W-1:0] ci_reg;
    logic [COIN_W-1:0] cj_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] left_reg;
    logic [DATA_W-1:0] right_reg;

    logic              alu_op;
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic [DATA_W-1:0] alu_c;
    logic [DATA_W-1:0] alu_y;

    // Coin store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.coin_wr)
        begin
            coin_mem[coin_wr_addr] <= coin_wr_data;
        end
        coin_q <= coin_mem[coin_rd_addr];
    end

    // Interval table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.tab_wr)
        begin
            tab_mem[tab_wr_addr] <= alu_y;
        end
        tab_q <= tab_mem[tab_rd_addr];
    end

    // Neighbors of a short interval are empty and count as zero.
    assign nb_val = ctl.near ? '0 : tab_q;

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_op = ALU_MINADD;
        alu_a  = DATA_W'(ci_reg);
        alu_b  = x_reg;
        alu_c  = nb_val;
        if (ctl.right)
        begin
            alu_a = DATA_W'(cj_reg);
            alu_b = y_reg;
        end
        else if (ctl.tab_wr)
        begin
            alu_op = ALU_MAX;
            alu_a  = '0;
            alu_b  = left_reg;
            alu_c  = right_reg;
        end
    end

    crop_alu #(
        .DATA_W (DATA_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .c  (alu_c),
        .y  (alu_y)
    );

    // Operand and partial result registers of the cell at work.
    always_ff @(posedge clk)
    begin
        if (ctl.cap_x)
        begin
            x_reg  <= nb_val;
            ci_reg <= coin_q;
        end
        if (ctl.left)
        begin
            left_reg <= alu_y;
            y_reg    <= nb_val;
            cj_reg   <= coin_q;
        end
        if (ctl.right)
        begin
            right_reg <= alu_y;
        end
    end

    assign cell_value = alu_y;

endmodule

// ===== hw/rtl/coin_row_optimal_pick_unit.sv =====
`timescale 1ns / 1ps
// Sequence: a row of n coins takes n input beats, then the interval table is
// filled cell by cell (five steps per cell on the shared compare-add unit and
// the single table read port), then the result is registered for hand-off.
// Throughput: one coin beat per cycle while loading; no input is taken during
// the table fill or hand-off. Reset (rst_n low, asynchronous) empties the row
// and clears out_valid; the coin store and the table need no clearing.
// ----------------------------------------------------------------------------
// Coin row optimal pick unit
// Collects a row of coins, fills the two-player game interval table one cell
// at a time by diagonal, and returns the first player's best total.
// ----------------------------------------------------------------------------
module coin_row_optimal_pick_unit
    import crop_pkg::*;
#(
    parameter int MAX_COINS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [COIN_W-1:0] coin_value,
    input  logic              last_coin,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [RES_W-1:0]  best_total
);

    localparam int IDX_W  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CNT_W  = $clog2(MAX_COINS + 1);
    localparam int TAB_AW = (MAX_COINS > 1) ? $clog2(MAX_COINS * MAX_COINS) : 1;
    localparam int DATA_W = COIN_W + $clog2(MAX_COINS);

    // Sequencer states.
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RX   = 3'd1;
    localparam logic [2:0] S_RY   = 3'd2;
    localparam logic [2:0] S_RZ   = 3'd3;
    localparam logic [2:0] S_RT   = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  n_reg,      n_next;
    logic [IDX_W-1:0]  i_reg,      i_next;
    logic [IDX_W-1:0]  len_reg,    len_next;
    logic [DATA_W-1:0] res_reg,    res_next;
    logic              ovalid_reg, ovalid_next;
    logic [RES_W-1:0]  total_reg,  total_next;

    logic              in_beat;
    logic              out_free;
    logic              room;
    logic [IDX_W-1:0]  j_idx;
    logic [IDX_W-1:0]  n_last;
    logic [IDX_W-1:0]  rd_row;
    logic [IDX_W-1:0]  rd_col;
    logic [IDX_W-1:0]  coin_rd_addr;
    logic [TAB_AW-1:0] tab_rd_addr;
    logic [TAB_AW-1:0] tab_wr_addr;
    logic [DATA_W-1:0] cell_value;
    ctl_t              ctl;

    assign in_stall   = (state_reg != S_LOAD);
    assign in_beat    = in_valid && !in_stall;
    assign out_free   = !ovalid_reg || !out_stall;
    assign room       = (count_reg < CNT_W'(MAX_COINS));
    assign j_idx      = i_reg + len_reg;
    assign n_last     = IDX_W'(n_reg - CNT_W'(1));
    assign out_valid  = ovalid_reg;
    assign best_total = total_reg;

    // Neighbor cell and coin addresses for each read step.
    always_comb
    begin
        rd_row       = i_reg;
        rd_col       = j_idx - IDX_W'(2);
        coin_rd_addr = i_reg;
        case (state_reg)
            S_RX:
            begin
                rd_row = i_reg + IDX_W'(2);
                rd_col = j_idx;
            end
            S_RY:
            begin
                rd_row       = i_reg + IDX_W'(1);
                rd_col       = j_idx - IDX_W'(1);
                coin_rd_addr = j_idx;
            end
            default:
            begin
                rd_row = i_reg;
                rd_col = j_idx - IDX_W'(2);
            end
        endcase
    end

    assign tab_rd_addr = TAB_AW'(TAB_AW'(rd_row) * TAB_AW'(MAX_COINS) + TAB_AW'(rd_col));
    assign tab_wr_addr = TAB_AW'(TAB_AW'(i_reg) * TAB_AW'(MAX_COINS) + TAB_AW'(j_idx));

    // Datapath control for the current step.
    always_comb
    begin
        ctl.coin_wr = in_beat && room;
        ctl.cap_x   = (state_reg == S_RY);
        ctl.left    = (state_reg == S_RZ);
        ctl.right   = (state_reg == S_RT);
        ctl.tab_wr  = (state_reg == S_WR);
        ctl.near    = (len_reg <= IDX_W'(1));
    end

    crop_datapath #(
        .MAX_COINS (MAX_COINS),
        .IDX_W     (IDX_W),
        .TAB_AW    (TAB_AW),
        .DATA_W    (DATA_W)
    ) u_datapath (
        .clk          (clk),
        .ctl          (ctl),
        .coin_wr_addr (IDX_W'(count_reg)),
        .coin_wr_data (coin_value),
        .coin_rd_addr (coin_rd_addr),
        .tab_rd_addr  (tab_rd_addr),
        .tab_wr_addr  (tab_wr_addr),
        .cell_value   (cell_value)
    );

    // Sequencer: load the row, walk the cells by diagonal, hand off the result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        len_next    = len_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        total_next  = total_reg;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_beat)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_coin)
                    begin
                        n_next     = room ? count_reg + CNT_W'(1) : count_reg;
                        count_next = '0;
                        i_next     = '0;
                        len_next   = '0;
                        state_next = S_RX;
                    end
                end
            end
            S_RX: state_next = S_RY;
            S_RY: state_next = S_RZ;
            S_RZ: state_next = S_RT;
            S_RT: state_next = S_WR;
            S_WR:
            begin
                if (j_idx == n_last)
                begin
                    if (len_reg == n_last)
                    begin
                        res_next   = cell_value;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        len_next   = len_reg + IDX_W'(1);
                        i_next     = '0;
                        state_next = S_RX;
                    end
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_RX;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    total_next  = RES_W'(res_reg);
                    state_next  = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            len_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            len_reg    <= len_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        total_reg <= total_next;
    end

    // A new result beat appears only when the fill has finished.
    a_result_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result beat raised outside the hand-off step");

    // The row being solved always holds at least one coin.
    a_row_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> n_reg != '0)
        else $error("table fill started on an empty row");

    // Cells stay inside the row during the fill.
    a_cell_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> (CNT_W'(j_idx) < n_reg))
        else $error("cell column beyond the last coin");

    // The coin count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_COINS))
        else $error("coin count beyond store depth");

    // A write of the final cell is followed by the hand-off step.
    a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && j_idx == n_last && len_reg == n_last) |=> state_reg == S_DONE)
        else $error("fill did not end after the whole-row cell");

endmodule
